// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the deframer RTL.
// Include with the bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define CHK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("deframer check failed");

// Condition must never be true outside reset.
`define CHK_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("deframer forbidden condition seen");

`endif

// ----- rtl/bfd_pkg.sv -----
// Shared types and constants for the binary frame deframer.
// No dependencies; used by every module of the block.
package bfd_pkg;

   // Sync pair
   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   // Parser phase codes
   localparam logic [3:0] PH_SYNC1   = 4'd0;
   localparam logic [3:0] PH_SYNC2   = 4'd1;
   localparam logic [3:0] PH_CLASS   = 4'd2;
   localparam logic [3:0] PH_ID      = 4'd3;
   localparam logic [3:0] PH_LEN_LO  = 4'd4;
   localparam logic [3:0] PH_LEN_HI  = 4'd5;
   localparam logic [3:0] PH_PAYLOAD = 4'd6;
   localparam logic [3:0] PH_CK_A    = 4'd7;
   localparam logic [3:0] PH_CK_B    = 4'd8;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_GOOD     = 2'd1;
   localparam logic [1:0] KIND_BAD_SUM  = 2'd2;
   localparam logic [1:0] KIND_TOO_LONG = 2'd3;

   localparam logic [15:0] MAX_LENGTH_RESET = 16'd256;

   // Queue between parser and output stage
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] msg_length;
   } bfd_result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } bfd_q_status_type;

endpackage

// ----- rtl/bfd_front.sv -----
// Front part of the deframer: accepts bytes, tracks the frame and checksum,
// and pushes result items into the queue. Depends on bfd_pkg.
module bfd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_rx_byte,
   input  logic                        csr_valid,
   input  logic [15:0]                 csr_max_length,
   input  bfd_pkg::bfd_q_status_type   q_status,
   output logic                        push,
   output bfd_pkg::bfd_result_type     push_data
);
   import bfd_pkg::*;

   logic [3:0]  phase_ff, phase_in;
   logic [15:0] max_length_ff;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] seen_ff, seen_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic        accept;
   logic        emit;
   logic [7:0]  add_a;
   logic [7:0]  add_b;

   // Stall only when the queue has no free entry
   assign req_stall = q_status.full;
   assign accept    = req_valid & ~q_status.full;

   // Running Fletcher sums with the current byte added
   assign add_a = sum_a_ff + req_rx_byte;
   assign add_b = sum_b_ff + add_a;

   // Next state and result for one byte
   always_comb begin
      phase_in  = phase_ff;
      class_in  = class_ff;
      id_in     = id_ff;
      length_in = length_ff;
      seen_in   = seen_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      emit      = 1'b0;
      push_data = '0;
      unique case (phase_ff)
         PH_SYNC2: begin
            phase_in = (req_rx_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
         end
         PH_CLASS: begin
            class_in = req_rx_byte;
            sum_a_in = req_rx_byte;
            sum_b_in = req_rx_byte;
            phase_in = PH_ID;
         end
         PH_ID: begin
            id_in    = req_rx_byte;
            sum_a_in = add_a;
            sum_b_in = add_b;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = {8'h00, req_rx_byte};
            sum_a_in  = add_a;
            sum_b_in  = add_b;
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in = {req_rx_byte, length_ff[7:0]};
            sum_a_in  = add_a;
            sum_b_in  = add_b;
            seen_in   = '0;
            if (length_in > max_length_ff) begin
               phase_in       = PH_SYNC1;
               emit           = 1'b1;
               push_data.kind = KIND_TOO_LONG;
            end else begin
               phase_in = (length_in == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            sum_a_in = add_a;
            sum_b_in = add_b;
            seen_in  = seen_ff + 16'd1;
            if (seen_in >= length_ff) begin
               phase_in = PH_CK_A;
            end
            emit                 = 1'b1;
            push_data.kind       = KIND_PAYLOAD;
            push_data.data_byte  = req_rx_byte;
            push_data.byte_index = seen_ff;
         end
         PH_CK_A: begin
            if (req_rx_byte == sum_a_ff) begin
               phase_in = PH_CK_B;
            end else begin
               phase_in       = PH_SYNC1;
               emit           = 1'b1;
               push_data.kind = KIND_BAD_SUM;
            end
         end
         PH_CK_B: begin
            phase_in       = PH_SYNC1;
            emit           = 1'b1;
            push_data.kind = (req_rx_byte == sum_b_ff) ? KIND_GOOD : KIND_BAD_SUM;
         end
         // first sync hunt; unused codes land here too
         default: begin
            phase_in = (req_rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
         end
      endcase
      push_data.msg_class  = class_in;
      push_data.msg_id     = id_in;
      push_data.msg_length = length_in;
   end

   assign push = accept & emit;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SYNC1;
         max_length_ff <= MAX_LENGTH_RESET;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
         end
         if (csr_valid) begin
            max_length_ff <= csr_max_length;
         end
      end
   end

   // Frame fields and sums; always written before they are read
   always_ff @(posedge clock) begin
      if (accept) begin
         class_ff  <= class_in;
         id_ff     <= id_in;
         length_ff <= length_in;
         seen_ff   <= seen_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
      end
   end

endmodule

// ----- rtl/bfd_queue.sv -----
// Short item queue between the parser and the output stage.
// Depends on bfd_pkg for the result type.
module bfd_queue #(
   parameter int unsigned DEPTH = bfd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  bfd_pkg::bfd_result_type     push_data,
   input  logic                        pop,
   output bfd_pkg::bfd_result_type     pop_data,
   output bfd_pkg::bfd_q_status_type   status
);
   import bfd_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   bfd_result_type   entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Pointer wrap works for any depth from two up, power of two or not
   assign wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/bfd_back.sv -----
// Output stage: pulls items from the queue into the result register.
// Depends on bfd_pkg for the result and status types.
module bfd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  bfd_pkg::bfd_q_status_type   q_status,
   input  bfd_pkg::bfd_result_type     q_data,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bfd_pkg::bfd_result_type     rsp_data
);
   import bfd_pkg::*;

   logic           valid_ff, valid_in;
   bfd_result_type data_ff;

   // Load when the register is free or being taken
   assign pop      = ~q_status.empty & (~valid_ff | ~rsp_stall);
   assign valid_in = pop | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= q_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- rtl/binary_frame_deframer_top.sv -----
// Binary frame deframer top level.
// Depends on bfd_pkg, bfd_front, bfd_queue, bfd_back and assert_macros.svh.
//
// Usage:
//  - req_ channel: one received byte per item (req_rx_byte). An item is
//    taken when req_valid is high and req_stall is low.
//  - rsp_ channel: zero or one result item per byte: a payload byte with
//    its index, frame good, checksum bad or length too long, plus the
//    class, id and length of the current frame.
//  - csr_ channel: writes max_length; csr_ready is always high. Write only
//    while no item is in flight.
//  - Throughput: one byte per cycle while req_stall is low. Each result
//    reaches rsp_valid through the queue write and then the output
//    register.
//  - If the receiver stalls, results collect in the queue (QUEUE_DEPTH
//    items) plus the output register; req_stall rises when the queue is full.
//  - Reset (synchronous) empties the queue, drops rsp_valid, returns the
//    parser to the sync hunt and sets max_length to 256.
`include "assert_macros.svh"

module binary_frame_deframer_top #(
   parameter int unsigned QUEUE_DEPTH = bfd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_byte_index,
   output logic [7:0]  rsp_msg_class,
   output logic [7:0]  rsp_msg_id,
   output logic [15:0] rsp_msg_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_max_length
);
   import bfd_pkg::*;

   logic             push;
   bfd_result_type   push_data;
   logic             pop;
   bfd_result_type   pop_data;
   bfd_q_status_type q_status;
   bfd_result_type   rsp_data;

   assign csr_ready = 1'b1;

   // Parser
   bfd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .csr_valid      (csr_valid),
      .csr_max_length (csr_max_length),
      .q_status       (q_status),
      .push           (push),
      .push_data      (push_data)
   );

   // Result queue
   bfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // Output register
   bfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_data    (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind       = rsp_data.kind;
   assign rsp_data_byte  = rsp_data.data_byte;
   assign rsp_byte_index = rsp_data.byte_index;
   assign rsp_msg_class  = rsp_data.msg_class;
   assign rsp_msg_id     = rsp_data.msg_id;
   assign rsp_msg_length = rsp_data.msg_length;

   // Checks
   `CHK_ASSERT(a_status_zero_fields, clock, reset, rsp_valid && rsp_kind != KIND_PAYLOAD |-> rsp_data_byte == 8'h00 && rsp_byte_index == 16'h0000)
   `CHK_ASSERT(a_index_in_range, clock, reset, rsp_valid && rsp_kind == KIND_PAYLOAD |-> rsp_byte_index < rsp_msg_length)
   `CHK_NEVER(a_queue_status, clock, reset, q_status.full && q_status.empty)

endmodule
